// ===== hdl/sbsm_pkg.sv =====
`timescale 1ns / 1ps

package sbsm_pkg;

    // bus access kinds
    localparam logic [1:0] OP_CPU_READ  = 2'd0;
    localparam logic [1:0] OP_CPU_WRITE = 2'd1;
    localparam logic [1:0] OP_PPU_READ  = 2'd2;
    localparam logic [1:0] OP_PPU_WRITE = 2'd3;

    // result targets
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_WRAM    = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_CHR_RAM = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_CHR_USES_RAM  = 2'd0;
    localparam logic [1:0] CFG_PRG_PAGE_CNT  = 2'd1;
    localparam logic [1:0] CFG_HDR_VERT_MIRR = 2'd2;

    // serial loader register select (address bits 14..13)
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG      = 2'd3;

    localparam int unsigned SHIFT_BITS = 5;
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned MADDR_W    = 18;
    localparam int unsigned PAGE_CNT_W = 6;

    localparam logic [1:0] MIRR_VERTICAL   = 2'd2;
    localparam logic [1:0] MIRR_HORIZONTAL = 2'd3;

    // bank state seen by the address translation
    typedef struct packed {
        logic       chr_eight_k;
        logic       prg_thirty_two_k;
        logic       fix_first_bank;
        logic [4:0] chr_bank_low;
        logic [4:0] chr_bank_high;
        logic [3:0] prg_bank;
        logic       wram_disabled;
    } t_bank_state;

endpackage

// ===== hdl/sbsm_loader.sv =====
`timescale 1ns / 1ps

module sbsm_loader (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [1:0]           i_reg_sel,
    input  logic [7:0]           i_data,
    input  logic                 i_hdr_vertical,
    output sbsm_pkg::t_bank_state o_bank,
    output logic [1:0]           o_mirroring_next
);

    logic [4:0] r_shift_value, n_shift_value;
    logic [2:0] r_shift_count, n_shift_count;
    logic [4:0] r_control,     n_control;
    logic       r_control_written, n_control_written;
    sbsm_pkg::t_bank_state r_bank, n_bank;

    logic [1:0] hdr_bits;
    logic [4:0] shifted;
    logic [4:0] reset_ctrl;
    logic [2:0] count_inc;

    assign hdr_bits  = i_hdr_vertical ? sbsm_pkg::MIRR_VERTICAL : sbsm_pkg::MIRR_HORIZONTAL;
    assign shifted   = r_shift_value | (5'(i_data[0]) << r_shift_count);
    assign count_inc = r_shift_count + 3'd1;
    assign reset_ctrl = (r_control_written ? r_control : {3'b000, hdr_bits}) | 5'b01100;

    always_comb begin
        n_shift_value     = r_shift_value;
        n_shift_count     = r_shift_count;
        n_control         = r_control;
        n_control_written = r_control_written;
        n_bank            = r_bank;
        if (i_wr_en) begin
            if (i_data[7]) begin
                // loader reset, forces last bank fixed
                n_shift_value             = '0;
                n_shift_count             = '0;
                n_control                 = reset_ctrl;
                n_control_written         = 1'b1;
                n_bank.chr_eight_k        = ~reset_ctrl[4];
                n_bank.prg_thirty_two_k   = ~reset_ctrl[3];
                n_bank.fix_first_bank     = ~reset_ctrl[2];
            end else if (count_inc >= 3'(sbsm_pkg::SHIFT_BITS)) begin
                n_shift_value = '0;
                n_shift_count = '0;
                unique case (i_reg_sel)
                    sbsm_pkg::SEL_CONTROL: begin
                        n_control               = shifted;
                        n_control_written       = 1'b1;
                        n_bank.chr_eight_k      = ~shifted[4];
                        n_bank.prg_thirty_two_k = ~shifted[3];
                        n_bank.fix_first_bank   = ~shifted[2];
                    end
                    sbsm_pkg::SEL_CHR_LOW:  n_bank.chr_bank_low  = shifted;
                    sbsm_pkg::SEL_CHR_HIGH: n_bank.chr_bank_high = shifted;
                    sbsm_pkg::SEL_PRG: begin
                        n_bank.wram_disabled = shifted[4];
                        n_bank.prg_bank      = shifted[3:0];
                    end
                    default: n_bank = r_bank;
                endcase
            end else begin
                n_shift_value = shifted;
                n_shift_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_value     <= '0;
            r_shift_count     <= '0;
            r_control         <= '0;
            r_control_written <= 1'b0;
            r_bank            <= '0;
        end else begin
            r_shift_value     <= n_shift_value;
            r_shift_count     <= n_shift_count;
            r_control         <= n_control;
            r_control_written <= n_control_written;
            r_bank            <= n_bank;
        end
    end

    assign o_bank           = r_bank;
    // mirroring as it stands once this access has taken effect
    assign o_mirroring_next = n_control_written ? n_control[1:0] : hdr_bits;

endmodule

// ===== hdl/sbsm_map.sv =====
`timescale 1ns / 1ps

module sbsm_map (
    input  logic [1:0]                      i_op,
    input  logic [sbsm_pkg::ADDR_W-1:0]     i_address,
    input  sbsm_pkg::t_bank_state           i_bank,
    input  logic                            i_chr_uses_ram,
    input  logic [sbsm_pkg::PAGE_CNT_W-1:0] i_prg_page_count,
    output logic [2:0]                      o_target,
    output logic [sbsm_pkg::MADDR_W-1:0]    o_mem_address,
    output logic                            o_write_enable
);

    logic [3:0] last_bank;
    logic [3:0] prg_sel;
    logic [4:0] chr_sel;
    logic [5:0] cnt_m1;
    logic       prg_slot;
    logic       chr_slot;

    assign prg_slot = i_address[14];
    assign chr_slot = i_address[12];
    assign cnt_m1   = i_prg_page_count - 6'd1;

    always_comb begin
        if (i_prg_page_count == '0)   last_bank = 4'd0;
        else if (cnt_m1 > 6'd15)      last_bank = 4'd15;
        else                          last_bank = cnt_m1[3:0];
    end

    always_comb begin
        priority if (i_bank.prg_thirty_two_k) prg_sel = {i_bank.prg_bank[3:1], prg_slot};
        else if (i_bank.fix_first_bank)      prg_sel = prg_slot ? i_bank.prg_bank : 4'd0;
        else                                 prg_sel = prg_slot ? last_bank : i_bank.prg_bank;
    end

    always_comb begin
        if (i_bank.chr_eight_k) chr_sel = {i_bank.chr_bank_low[4:1], chr_slot};
        else                    chr_sel = chr_slot ? i_bank.chr_bank_high : i_bank.chr_bank_low;
    end

    always_comb begin
        o_target       = sbsm_pkg::TGT_NONE;
        o_mem_address  = '0;
        o_write_enable = 1'b0;
        unique case (i_op)
            sbsm_pkg::OP_CPU_READ, sbsm_pkg::OP_CPU_WRITE: begin
                if (i_address[15]) begin
                    // writes up here feed the serial loader instead
                    if (i_op == sbsm_pkg::OP_CPU_READ) begin
                        o_target      = sbsm_pkg::TGT_PRG_ROM;
                        o_mem_address = {prg_sel, i_address[13:0]};
                    end
                end else if (i_address[14:13] == 2'b11 && !i_bank.wram_disabled) begin
                    o_target       = sbsm_pkg::TGT_WRAM;
                    o_mem_address  = {5'd0, i_address[12:0]};
                    o_write_enable = (i_op == sbsm_pkg::OP_CPU_WRITE);
                end
            end
            sbsm_pkg::OP_PPU_READ, sbsm_pkg::OP_PPU_WRITE: begin
                if (i_address[15:13] == 3'b000) begin
                    if (i_chr_uses_ram) begin
                        o_target       = sbsm_pkg::TGT_CHR_RAM;
                        o_mem_address  = {5'd0, i_address[12:0]};
                        o_write_enable = (i_op == sbsm_pkg::OP_PPU_WRITE);
                    end else if (i_op == sbsm_pkg::OP_PPU_READ) begin
                        o_target      = sbsm_pkg::TGT_CHR_ROM;
                        o_mem_address = {1'b0, chr_sel, i_address[11:0]};
                    end
                end
            end
            default: o_target = sbsm_pkg::TGT_NONE;
        endcase
    end

endmodule

// ===== hdl/serial_bank_switch_mapper_top.sv =====
`timescale 1ns / 1ps

// serial bank-switch cartridge mapper: each beat on the slave stream is one cpu or ppu
// bus access and yields exactly one beat on the master stream, in order, with the
// target memory, the physical byte address in it, a write enable and the nametable
// mirroring in force after the access. cpu writes at 0x8000 and up drive the five-bit
// serial loader and give target none. one access is taken every clock unless the result
// stream stalls: the mapping is a single level of decode between the bank registers and
// the result register, and a new beat is accepted whenever the result register is empty
// or being drained, so a beat's result is registered in the cycle after it is accepted. the
// user must write configuration (chr ram, prg page count, header mirroring) through the
// cfg channel (always ready) only while no access is in flight; this is not enforced.

module serial_bank_switch_mapper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // mem_address[17:0], write_enable[18], mirroring[20:19], 0
    output logic [2:0]  m_tuser,   // target[2:0]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    // configuration registers
    logic                            r_chr_uses_ram;
    logic [sbsm_pkg::PAGE_CNT_W-1:0] r_prg_page_count;
    logic                            r_hdr_vertical;

    // result register
    logic                            r_out_valid;
    logic [2:0]                      r_target;
    logic [sbsm_pkg::MADDR_W-1:0]    r_mem_address;
    logic                            r_write_enable;
    logic [1:0]                      r_mirroring;

    logic                            accept;
    logic [1:0]                      in_op;
    logic [sbsm_pkg::ADDR_W-1:0]     in_address;
    logic [7:0]                      in_data;
    logic                            loader_wr;
    sbsm_pkg::t_bank_state           bank;
    logic [1:0]                      mirroring_next;
    logic [2:0]                      map_target;
    logic [sbsm_pkg::MADDR_W-1:0]    map_mem_address;
    logic                            map_write_enable;

    assign in_op      = s_tuser;
    assign in_address = s_tdata[15:0];
    assign in_data    = s_tdata[23:16];

    // result register frees up when empty or when its beat is taken
    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    // serial loader sees cpu writes at 0x8000 and above
    assign loader_wr = accept && (in_op == sbsm_pkg::OP_CPU_WRITE) && in_address[15];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_uses_ram   <= 1'b0;
            r_prg_page_count <= 6'd16;
            r_hdr_vertical   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sbsm_pkg::CFG_CHR_USES_RAM:  r_chr_uses_ram   <= i_cfg_data[0];
                sbsm_pkg::CFG_PRG_PAGE_CNT:  r_prg_page_count <= i_cfg_data;
                sbsm_pkg::CFG_HDR_VERT_MIRR: r_hdr_vertical   <= i_cfg_data[0];
                default: ;  // unknown index, dropped
            endcase
        end
    end

    sbsm_loader u_loader (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr_en          (loader_wr),
        .i_reg_sel        (in_address[14:13]),
        .i_data           (in_data),
        .i_hdr_vertical   (r_hdr_vertical),
        .o_bank           (bank),
        .o_mirroring_next (mirroring_next)
    );

    // translation uses the bank state from before this beat
    sbsm_map u_map (
        .i_op             (in_op),
        .i_address        (in_address),
        .i_bank           (bank),
        .i_chr_uses_ram   (r_chr_uses_ram),
        .i_prg_page_count (r_prg_page_count),
        .o_target         (map_target),
        .o_mem_address    (map_mem_address),
        .o_write_enable   (map_write_enable)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target       <= map_target;
            r_mem_address  <= map_mem_address;
            r_write_enable <= map_write_enable;
            r_mirroring    <= mirroring_next;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_target;
    assign m_tdata  = {3'b000, r_mirroring, r_write_enable, r_mem_address};

endmodule
